// ===== rtl/iqpkt_pkg.sv =====
// ----------------------------------------------------------------------------
// iqpkt_pkg
// Shared types and constants of the IQ sample packetizer.
// ----------------------------------------------------------------------------
package iqpkt_pkg;

    localparam int unsigned SPP_W = 20;

    typedef enum logic [1:0] {
        KIND_HDR_LO = 2'd0,
        KIND_HDR_HI = 2'd1,
        KIND_DATA   = 2'd2
    } word_kind_t;

    typedef enum logic [1:0] {
        REG_SPP    = 2'd0,
        REG_FORMAT = 2'd1,
        REG_HEADER = 2'd2
    } reg_index_t;

    // One classified job passed from the front end to the back end
    typedef struct packed {
        logic [31:0] data_a;    // int16 word, or raw I
        logic [31:0] data_b;    // raw Q
        logic        two_words; // float mode
        logic        has_hdr;
        logic [63:0] seq;
        logic        last;
    } job_t;

    // Convert an IEEE single to int16: x32768, saturate, round half to even
    function automatic logic [15:0] to_int16(input logic [31:0] bits);
        logic [7:0]  e;
        logic [23:0] m;
        logic [63:0] fx;
        logic [16:0] ip;
        logic        g;
        logic        st;
        logic [16:0] r;
        logic [15:0] res;
        e   = bits[30:23];
        m   = {1'b1, bits[22:0]};
        fx  = '0;
        res = '0;
        if (e == 8'hFF && bits[22:0] != '0) begin
            res = '0;
        end else if (e >= 8'd127) begin
            // magnitude of at least 1.0 scales to 32768 or more: saturate
            res = bits[31] ? 16'h8000 : 16'h7FFF;
        end else if (e == 8'd0) begin
            res = '0;
        end else begin
            // value*32768 = m * 2^(e-135); keep 40 fraction bits for round and sticky
            fx  = {m, 40'd0} >> (8'd135 - e);
            ip  = fx[56:40];
            g   = fx[39];
            st  = fx[38:0] != '0;
            r   = ip + {16'd0, g & (st | ip[0])};
            if (bits[31]) begin
                res = (r > 17'd32768) ? 16'h8000 : 16'(17'd0 - r);
            end else begin
                res = (r > 17'd32767) ? 16'h7FFF : r[15:0];
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/iq_sample_packetizer_core.sv =====
// ----------------------------------------------------------------------------
// iq_sample_packetizer_core
// Frames IQ samples into packets of 32-bit words with optional sequence header.
// Latency: the first word of a sample passes the queue, then the output register.
// Throughput: one output word per cycle while m_tready is high; 1 to 4 words per sample.
// Reset: aresetn synchronous; clears framing, sequence and restores registers.
// ----------------------------------------------------------------------------
module iq_sample_packetizer_core import iqpkt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [64:0] s_tdata,   // sample_i[31:0], sample_q[63:32], block_end[64]
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic [31:0] m_tdata,   // word
    output logic [3:0]  m_tuser,   // word_kind[1:0], packet_end[2], item_end[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    logic [SPP_W-1:0] spp_reg;
    logic             fmt_reg;
    logic             hdr_reg;
    job_t             fjob;
    job_t             bjob;
    logic             fv, fr, bv, br;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spp_reg <= SPP_W'(373);
            fmt_reg <= 1'b0;
            hdr_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SPP:    spp_reg <= cfg_data;
                REG_FORMAT: fmt_reg <= cfg_data[0];
                REG_HEADER: hdr_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    iqpkt_front u_front (
        .aclk, .aresetn, .spp(spp_reg), .fmt(fmt_reg), .hdr_en(hdr_reg),
        .in_data(s_tdata[63:0]), .in_valid(s_tvalid), .in_ready(s_tready),
        .job(fjob), .job_valid(fv), .job_ready(fr)
    );

    iqpkt_queue u_queue (
        .aclk, .aresetn, .wr_job(fjob), .wr_valid(fv), .wr_ready(fr),
        .rd_job(bjob), .rd_valid(bv), .rd_ready(br)
    );

    iqpkt_back u_back (
        .aclk, .aresetn, .job(bjob), .job_valid(bv), .job_ready(br),
        .m_tdata, .m_tuser, .m_tvalid, .m_tready
    );

endmodule

// ===== rtl/iqpkt_front.sv =====
// ----------------------------------------------------------------------------
// iqpkt_front
// Accepts samples, tracks framing and sequence state, converts to int16 (float mode passes raw).
// ----------------------------------------------------------------------------
module iqpkt_front import iqpkt_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [SPP_W-1:0] spp,
    input  logic             fmt,
    input  logic             hdr_en,
    input  logic [63:0]      in_data,
    input  logic             in_valid,
    output logic             in_ready,
    output job_t             job,
    output logic             job_valid,
    input  logic             job_ready
);

    localparam logic [SPP_W-1:0] MAX_SPP = SPP_W'(1000000);

    logic [SPP_W-1:0] fill_reg;
    logic [SPP_W-1:0] fill_next;
    logic [63:0]      seq_reg;
    logic [63:0]      seq_next;
    logic [SPP_W-1:0] size;
    logic             last;
    logic             acc;

    assign in_ready = job_ready;
    assign acc      = in_valid && job_ready;
    assign job_valid = in_valid;

    // Clamp the packet size into range
    always_comb begin
        size = spp;
        if (spp == '0) size = SPP_W'(1);
        if (spp > MAX_SPP) size = MAX_SPP;
        last = (fill_reg + SPP_W'(1)) >= size;
    end

    // Classify the sample into a job
    always_comb begin
        job.data_a    = fmt ? in_data[31:0]
                            : {to_int16(in_data[63:32]), to_int16(in_data[31:0])};
        job.data_b    = in_data[63:32];
        job.two_words = fmt;
        job.has_hdr   = (fill_reg == '0) && hdr_en;
        job.seq       = seq_reg;
        job.last      = last;
    end

    // Advance framing state
    always_comb begin
        fill_next = fill_reg;
        seq_next  = seq_reg;
        if (acc) begin
            if (last) begin
                fill_next = '0;
                if (hdr_en) seq_next = seq_reg + 64'd1;
            end else begin
                fill_next = fill_reg + SPP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            seq_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            seq_reg  <= seq_next;
        end
    end

endmodule

// ===== rtl/iqpkt_queue.sv =====
// ----------------------------------------------------------------------------
// iqpkt_queue
// Two-entry job queue between front end and back end.
// ----------------------------------------------------------------------------
module iqpkt_queue import iqpkt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  job_t wr_job,
    input  logic wr_valid,
    output logic wr_ready,
    output job_t rd_job,
    output logic rd_valid,
    input  logic rd_ready
);

    job_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       wr;
    logic       rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_job   = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // Store incoming job
    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

endmodule

// ===== rtl/iqpkt_back.sv =====
// ----------------------------------------------------------------------------
// iqpkt_back
// Serializes each job into header and data words with a registered output.
// ----------------------------------------------------------------------------
module iqpkt_back import iqpkt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  job_t        job,
    input  logic        job_valid,
    output logic        job_ready,
    output logic [31:0] m_tdata,
    output logic [3:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);

    logic [1:0]  step_reg;
    logic [1:0]  step_next;
    logic [1:0]  step_cur;
    logic [1:0]  first;
    logic [1:0]  fin;
    logic [31:0] w;
    word_kind_t  k;
    logic        pend;
    logic        iend;
    logic        load;
    logic [31:0] tdata_reg;
    logic [3:0]  tuser_reg;
    logic        tvalid_reg;

    // Steps: 0 hdr lo, 1 hdr hi, 2 data a, 3 data b
    assign first = job.has_hdr ? 2'd0 : 2'd2;
    assign fin   = job.two_words ? 2'd3 : 2'd2;

    // Skip the header steps when the job has none
    assign step_cur = (step_reg < first) ? first : step_reg;

    assign load      = job_valid && (!tvalid_reg || m_tready);
    assign job_ready = load && (step_cur == fin);

    always_comb begin
        unique case (step_cur)
            2'd0:    begin w = job.seq[31:0];  k = KIND_HDR_LO; end
            2'd1:    begin w = job.seq[63:32]; k = KIND_HDR_HI; end
            2'd2:    begin w = job.data_a;     k = KIND_DATA;   end
            default: begin w = job.data_b;     k = KIND_DATA;   end
        endcase
        iend = step_cur == fin;
        pend = iend && job.last;
        step_next = step_reg;
        if (load) step_next = iend ? 2'd0 : step_cur + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tdata_reg <= w;
            tuser_reg <= {iend, pend, k};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= 2'd0;
            tvalid_reg <= 1'b0;
        end else begin
            if (load) tvalid_reg <= 1'b1;
            else if (m_tready) tvalid_reg <= 1'b0;
            step_reg <= step_next;
        end
    end

    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tvalid = tvalid_reg;

endmodule

// ===== tb/tb_iq_sample_packetizer_core.sv =====
// ----------------------------------------------------------------------------
// tb_iq_sample_packetizer_core
// Self-checking bench for the IQ sample packetizer. Samples enter on the
// s_ stream, packet words leave on the m_ stream. A local model frames every
// accepted sample into expected words; each output transaction is compared
// against the oldest one. Register settings, idle rates and a long output
// stall vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_iq_sample_packetizer_core;
    import iqpkt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PKT_MAX = 1000000;

    typedef struct {
        logic [31:0] i_bits;
        logic [31:0] q_bits;
        logic        blk_end;
    } sample_t;

    typedef struct {
        logic [31:0] word;
        word_kind_t  kind;
        logic        pkt_end;
        logic        smp_end;
    } pkt_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [64:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;

    // Stimulus and expectation stores
    sample_t     sample_q[$];
    pkt_word_t   word_q[$];
    logic        in_acc = 1'b0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        rx_hold_go = 1'b0;
    logic        rx_hold_seen = 1'b0;
    int unsigned rx_hold_cnt = 0;
    int unsigned errors = 0;

    // Model state and register copies
    logic [19:0] spp_reg;
    logic        fmt_reg;
    logic        hdr_reg;
    logic [19:0] fill_cnt;
    logic [63:0] seq_num;

    iq_sample_packetizer_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Scale an IEEE single by 2^15, round half to even, saturate to int16
    function automatic logic [15:0] quantize_q15(input logic [31:0] b);
        logic [7:0]  e;
        logic [31:0] m;
        int unsigned sh;
        logic [31:0] ip;
        logic [31:0] rem;
        logic [31:0] half;
        logic [31:0] nv;
        e = b[30:23];
        m = {8'd0, 1'b1, b[22:0]};
        if (e == 8'hFF && b[22:0] != '0) return 16'h0000;
        if (e == 8'd0) return 16'h0000;
        if (e >= 8'd135) return b[31] ? 16'h8000 : 16'h7FFF;
        sh = 135 - e;
        if (sh > 25) return 16'h0000;
        ip   = m >> sh;
        rem  = m & ((32'd1 << sh) - 32'd1);
        half = 32'd1 << (sh - 1);
        if (rem > half || (rem == half && ip[0])) ip = ip + 32'd1;
        if (!b[31]) return (ip > 32'd32767) ? 16'h7FFF : ip[15:0];
        nv = 32'd0 - ip;
        return (ip > 32'd32768) ? 16'h8000 : nv[15:0];
    endfunction

    function automatic void push_word(input logic [31:0] w, input word_kind_t k,
                                      input logic pe);
        pkt_word_t x;
        x.word = w;
        x.kind = k;
        x.pkt_end = pe;
        x.smp_end = 1'b0;
        word_q.push_back(x);
    endfunction

    // Frame one sample into the words it produces and advance packet state
    function automatic void frame_sample(input logic [31:0] ib, input logic [31:0] qb);
        logic [20:0] size;
        logic        last;
        size = (spp_reg == '0) ? 21'd1 : (spp_reg > PKT_MAX) ? 21'(PKT_MAX) : {1'b0, spp_reg};
        last = ({1'b0, fill_cnt} + 21'd1) >= size;
        if (fill_cnt == '0 && hdr_reg) begin
            push_word(seq_num[31:0], KIND_HDR_LO, 1'b0);
            push_word(seq_num[63:32], KIND_HDR_HI, 1'b0);
        end
        if (fmt_reg) begin
            push_word(ib, KIND_DATA, 1'b0);
            push_word(qb, KIND_DATA, last);
        end else begin
            push_word({quantize_q15(qb), quantize_q15(ib)}, KIND_DATA, last);
        end
        word_q[word_q.size() - 1].smp_end = 1'b1;
        if (last) begin
            fill_cnt = '0;
            if (hdr_reg) seq_num = seq_num + 64'd1;
        end else begin
            fill_cnt = fill_cnt + 20'd1;
        end
    endfunction

    // Track register writes and accepted samples, check output transactions
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_acc   <= 1'b0;
            spp_reg  = 20'd373;
            fmt_reg  = 1'b0;
            hdr_reg  = 1'b1;
            fill_cnt = '0;
            seq_num  = '0;
            word_q.delete();
        end else begin
            in_acc <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                case (reg_index_t'(cfg_index))
                    REG_SPP:    spp_reg = cfg_data;
                    REG_FORMAT: fmt_reg = cfg_data[0];
                    REG_HEADER: hdr_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) frame_sample(s_tdata[31:0], s_tdata[63:32]);
            if (m_tvalid && m_tready) begin
                if (word_q.size() == 0) begin
                    errors++;
                    $display("%t unexpected word: expected none, actual %h user %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    if (m_tdata !== word_q[0].word || m_tuser[1:0] !== word_q[0].kind ||
                        m_tuser[2] !== word_q[0].pkt_end || m_tuser[3] !== word_q[0].smp_end)
                    begin
                        errors++;
                        $display("%t word mismatch: expected %h kind %0d pend %b iend %b,",
                                 $time, word_q[0].word, word_q[0].kind, word_q[0].pkt_end,
                                 word_q[0].smp_end, " actual %h kind %0d pend %b iend %b",
                                 m_tdata, m_tuser[1:0], m_tuser[2], m_tuser[3]);
                    end
                    void'(word_q.pop_front());
                end
            end
        end
    end

    // Sample driver: hold an offered sample until taken, then maybe idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !in_acc)) begin
            if (s_tvalid) void'(sample_q.pop_front());
            if (sample_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {sample_q[0].blk_end, sample_q[0].q_bits, sample_q[0].i_bits};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Word receiver: random stalls plus one long hold-off on request
    always @(negedge aclk) begin
        if (rx_hold_go && !rx_hold_seen) begin
            rx_hold_seen <= 1'b1;
            rx_hold_cnt  <= 400;
            m_tready     <= 1'b0;
        end else if (rx_hold_cnt > 0) begin
            rx_hold_cnt <= rx_hold_cnt - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [19:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_sample(input logic [31:0] ib, input logic [31:0] qb);
        sample_t s;
        s.i_bits = ib;
        s.q_bits = qb;
        s.blk_end = 1'($urandom_range(1));
        sample_q.push_back(s);
    endtask

    // Mostly values near full scale, some specials, some raw bit patterns
    function automatic logic [31:0] rand_float();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 2) return $urandom();
        if (sel == 2) begin
            case ($urandom_range(5))
                0: return 32'h7FC00000;
                1: return 32'h7F800000;
                2: return 32'hFF800000;
                3: return 32'h80000000;
                4: return {1'($urandom_range(1)), 8'd0, 23'($urandom())};
                default: return {1'($urandom_range(1)), 8'd112, 23'($urandom())};
            endcase
        end
        return {1'($urandom_range(1)), 8'($urandom_range(135, 100)), 23'($urandom())};
    endfunction

    task automatic add_random(input int n);
        repeat (n) add_sample(rand_float(), rand_float());
    endtask

    // Wait for all samples taken and all words seen
    task automatic drain();
        while (sample_q.size() > 0 || s_tvalid || word_q.size() > 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [19:0] spp, input logic fmt, input logic hdr,
                             input int n);
        write_reg(REG_SPP, spp);
        write_reg(REG_FORMAT, fmt);
        write_reg(REG_HEADER, hdr);
        add_random(n);
        drain();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Directed: conversion corners, ties, specials, then format and size edges
        tx_idle_pct = 28;
        rx_idle_pct = 88;
        write_reg(REG_SPP, 20'd3);
        add_sample(32'h00000000, 32'h3F800000);
        add_sample(32'hBF800000, 32'h37800000);
        add_sample(32'h38400000, 32'h38200000);
        add_sample(32'h7FC00000, 32'hFFFFFFFF);
        add_sample(32'h7F800000, 32'hFF800000);
        add_sample(32'h7F7FFFFF, 32'hFF7FFFFF);
        add_sample(32'h00000001, 32'h80000000);
        add_sample(32'h3F7FFFFF, 32'hBF7FFFFF);
        add_sample(32'hB8400000, 32'hB8200000);
        add_sample(32'hFFFFFFFF, 32'h00000000);
        drain();
        write_reg(REG_FORMAT, 1'b1);
        write_reg(REG_HEADER, 1'b0);
        write_reg(REG_SPP, 20'd0);
        add_sample(32'hFFFFFFFF, 32'h00000000);
        add_sample(32'h00000000, 32'hFFFFFFFF);
        drain();
        write_reg(REG_HEADER, 1'b1);
        write_reg(REG_SPP, 20'hFFFFF);
        add_sample(32'h12345678, 32'h9ABCDEF0);
        add_sample(32'h7FC00000, 32'h7F800000);
        drain();
        // Shrink the size mid-packet and drop the header
        write_reg(REG_SPP, 20'd1);
        write_reg(REG_HEADER, 1'b0);
        add_sample(32'h3F000000, 32'hBF000000);
        add_sample(32'h3E800000, 32'hBE800000);
        drain();

        // Random phases, receiver slow side first, then sender slow side, then neither
        run_phase(20'd2, 1'b0, 1'b1, 40);
        run_phase(20'd5, 1'b1, 1'b1, 40);
        run_phase(20'd1000000, 1'b0, 1'b1, 15);
        tx_idle_pct = 88;
        rx_idle_pct = 28;
        run_phase(20'd3, 1'b1, 1'b0, 40);
        run_phase(20'd7, 1'b0, 1'b1, 40);
        run_phase(20'd0, 1'b0, 1'b1, 30);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(20'd4, 1'b1, 1'b1, 40);

        // Long output stall while samples keep coming
        write_reg(REG_SPP, 20'd6);
        add_random(60);
        rx_hold_go = 1'b1;
        drain();
        run_phase(20'd1, 1'b1, 1'b1, 30);
        run_phase(20'd17, 1'b0, 1'b0, 40);
        run_phase(20'd9, 1'b0, 1'b1, 80);

        repeat (20) @(negedge aclk);
        if (word_q.size() != 0) errors++;
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== iq_sample_packetizer_core.f =====
rtl/iqpkt_pkg.sv
rtl/iqpkt_front.sv
rtl/iqpkt_queue.sv
rtl/iqpkt_back.sv
rtl/iq_sample_packetizer_core.sv
tb/tb_iq_sample_packetizer_core.sv
